### src/assert_macros.svh
// Assertion macros for the signal light history voter RTL; slhv_ctrl uses them.
// Each macro expects clk and rst_n in scope; it depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SLHV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define SLHV_NEVER(label, cond, msg) \
    `SLHV_ASSERT(label, !(cond), msg)

`endif

### src/slhv_pkg.sv
// Shared types and constants of the signal light history voter.
// Used by slhv_ctrl, slhv_datapath and the top level; depends on nothing.
package slhv_pkg;

    // Command codes carried in the input tuser field.
    localparam logic [1:0] CMD_FRAME      = 2'd0;
    localparam logic [1:0] CMD_MISS_KEEP  = 2'd1;
    localparam logic [1:0] CMD_MISS_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam int         CFG_INDEX_W  = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_JUMP  = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [6:0]  TOL_RESET  = 7'd1;
    localparam logic [15:0] JUMP_RESET = 16'd200;
    localparam logic [31:0] LIM_RESET  = 32'(JUMP_RESET) * 32'(JUMP_RESET);

    // Visibility counter limits and reset value.
    localparam logic signed [15:0] VIS_MAX   = 16'sh7FFF;
    localparam logic signed [15:0] VIS_MIN   = 16'sh8000;
    localparam logic signed [15:0] VIS_RESET = -16'sd1;

    // Cycles from the last ring read until the jump flag is settled.
    localparam int          DRAIN_W      = 2;
    localparam logic [DRAIN_W-1:0] DRAIN_LAST = 2'd2;

    // Lamp vote codes.
    typedef enum logic [1:0] {
        LAMP_OFF   = 2'd0,
        LAMP_ON    = 2'd1,
        LAMP_BLINK = 2'd2,
        LAMP_UNDEC = 2'd3
    } lamp_t;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_PARTIAL   = 3'd0,
        STAT_VOTED     = 3'd1,
        STAT_JUMP      = 3'd2,
        STAT_UNDECIDED = 3'd3,
        STAT_MISS      = 3'd4
    } status_t;

    // What the current word needs after it has been taken.
    typedef enum logic [1:0] {
        KIND_MISS    = 2'd0,
        KIND_PARTIAL = 2'd1,
        KIND_WALK    = 2'd2
    } kind_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // One ring entry: lamp bits (red at bit 0) and target position.
    typedef struct packed {
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic [2:0]         lamps;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic walk_rd;
        logic walk_first;
        logic emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        kind_t kind;
        logic  out_free;
    } dp_status_t;

endpackage

### src/slhv_ctrl.sv
// Controller state machine of the signal light history voter.
// Depends on slhv_pkg and assert_macros.svh; drives slhv_datapath by commands.
`include "assert_macros.svh"

module slhv_ctrl
    import slhv_pkg::*;
#(
    parameter int HISTORY_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t dp_st,
    output ctrl_cmd_t  cmd
);

    localparam int WALK_W = $clog2(HISTORY_DEPTH);
    localparam logic [WALK_W-1:0] WALK_LAST = WALK_W'(HISTORY_DEPTH - 1);

    state_t              state_reg, state_next;
    logic [WALK_W-1:0]   walk_cnt_reg, walk_cnt_next;
    logic [DRAIN_W-1:0]  drain_cnt_reg, drain_cnt_next;

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            walk_cnt_reg  <= '0;
            drain_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_cnt_reg  <= walk_cnt_next;
            drain_cnt_reg <= drain_cnt_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (dp_st.kind == KIND_WALK)
                    state_next = ST_WALK;
                else
                    state_next = ST_FINISH;
            end
            ST_WALK:
            begin
                if (walk_cnt_reg == WALK_LAST)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (drain_cnt_reg == DRAIN_LAST)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (dp_st.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Walk and drain counters run only in their own states.
    always_comb
    begin
        walk_cnt_next  = (state_reg == ST_WALK)  ? walk_cnt_reg + 1'b1  : '0;
        drain_cnt_next = (state_reg == ST_DRAIN) ? drain_cnt_reg + 1'b1 : '0;
    end

    // Outputs and datapath commands.
    always_comb
    begin
        s_tready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            ST_WALK:
            begin
                cmd.walk_rd    = 1'b1;
                cmd.walk_first = (walk_cnt_reg == '0);
            end
            ST_FINISH:
            begin
                cmd.emit = dp_st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `SLHV_ASSERT(a_emit_needs_slot, cmd.emit |-> dp_st.out_free, "result loaded into a full slot")
    `SLHV_ASSERT(a_take_to_decide, cmd.take |=> (state_reg == ST_DECIDE), "taken word not decided")
    `SLHV_ASSERT(a_short_path, (state_reg == ST_DECIDE && dp_st.kind != KIND_WALK) |=> (state_reg == ST_FINISH), "miss or partial word walked the ring")
    `SLHV_ASSERT(a_walk_length, (state_reg == ST_WALK && walk_cnt_reg == WALK_LAST) |=> (state_reg == ST_DRAIN), "walk ran past the ring depth")

endmodule

### src/slhv_datapath.sv
// Datapath of the signal light history voter: ring memory, jump pipeline,
// lamp counters, voting, visibility counter and output register. Uses slhv_pkg.
module slhv_datapath
    import slhv_pkg::*;
#(
    parameter int HISTORY_DEPTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             dp_st,
    input  logic [39:0]            s_tdata,
    input  logic [1:0]             s_tuser,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [23:0]            m_tdata,
    output logic [3:0]             m_tuser
);

    localparam int HEAD_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int VOTE_W = ((CNT_W > 7) ? CNT_W : 7) + 2;
    localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(HISTORY_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_PART  = CNT_W'(HISTORY_DEPTH - 1);

    // Vote one lamp from its on-frame count.
    function automatic lamp_t vote_lamp(input logic [CNT_W-1:0] c, input logic [6:0] t);
        logic signed [VOTE_W-1:0] cs;
        logic signed [VOTE_W-1:0] ts;
        logic signed [VOTE_W-1:0] n;
        logic signed [VOTE_W-1:0] h;
        lamp_t                    v;
        cs = $signed(VOTE_W'(c));
        ts = $signed(VOTE_W'(t));
        n  = $signed(VOTE_W'(HISTORY_DEPTH));
        h  = $signed(VOTE_W'(HISTORY_DEPTH / 2));
        if (cs > n - ts)
            v = LAMP_ON;
        else if (cs > h - ts && cs < h + ts)
            v = LAMP_BLINK;
        else if (cs < ts)
            v = LAMP_OFF;
        else
            v = LAMP_UNDEC;
        return v;
    endfunction

    entry_t              ring_mem [HISTORY_DEPTH];
    entry_t              in_entry;
    logic [1:0]          in_cmd;
    logic                wr_en;

    logic [6:0]          tol_reg;
    logic [15:0]         jump_mm_reg;
    logic [31:0]         lim_reg;

    logic [HEAD_W-1:0]   head_reg, ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    kind_t               kind_reg;
    logic [2:0]          item_lamps_reg;

    entry_t              rd_data_reg;
    logic                v1_reg, f1_reg, v2_reg, v3_reg;
    logic signed [15:0]  prev_x_reg, prev_y_reg;
    logic [15:0]         adx_reg, ady_reg;
    logic [31:0]         sqx_reg, sqy_reg;
    logic                jump_reg;
    logic [CNT_W-1:0]    cnt_r_reg, cnt_y_reg, cnt_g_reg;
    logic signed [16:0]  dx, dy;
    logic [32:0]         dist2;

    logic signed [15:0]  vis_reg, vis_next;
    logic [5:0]          held_reg;
    lamp_t               vote_r, vote_y, vote_g;
    logic                report;
    logic [5:0]          res_states;
    logic                res_ready;
    status_t             res_status;

    logic                out_valid_reg;
    logic [5:0]          out_states_reg;
    logic                out_ready_reg;
    logic signed [15:0]  out_vis_reg;
    status_t             out_status_reg;

    // Input word unpacking.
    assign in_entry.lamps = s_tdata[2:0];
    assign in_entry.x     = s_tdata[18:3];
    assign in_entry.y     = s_tdata[34:19];
    assign in_cmd         = s_tuser;
    assign wr_en          = cmd.take && (in_cmd == CMD_FRAME);

    // Configuration registers; the squared jump limit follows in the next cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg     <= TOL_RESET;
            jump_mm_reg <= JUMP_RESET;
            lim_reg     <= LIM_RESET;
        end
        else
        begin
            lim_reg <= 32'(jump_mm_reg) * 32'(jump_mm_reg);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TOLERANCE: tol_reg     <= cfg_data[6:0];
                    CFG_MAX_JUMP:  jump_mm_reg <= cfg_data;
                    default:       tol_reg     <= tol_reg;
                endcase
            end
        end
    end

    // Ring memory: one write port at the head, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            ring_mem[head_reg] <= in_entry;
        if (cmd.walk_rd)
            rd_data_reg <= ring_mem[ptr_reg];
    end

    // Ring bookkeeping and classification of the taken word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            ptr_reg        <= '0;
            count_reg      <= '0;
            kind_reg       <= KIND_MISS;
            item_lamps_reg <= '0;
        end
        else if (cmd.take)
        begin
            item_lamps_reg <= in_entry.lamps;
            if (in_cmd == CMD_FRAME)
            begin
                // The walk starts at the slot being written now.
                ptr_reg  <= head_reg;
                head_reg <= (head_reg == HEAD_LAST) ? '0 : head_reg + 1'b1;
                if (count_reg != CNT_FULL)
                    count_reg <= count_reg + 1'b1;
                kind_reg <= (count_reg < CNT_PART) ? KIND_PARTIAL : KIND_WALK;
            end
            else
            begin
                if (in_cmd == CMD_MISS_CLEAR)
                begin
                    head_reg  <= '0;
                    count_reg <= '0;
                end
                kind_reg <= KIND_MISS;
            end
        end
        else if (cmd.walk_rd)
        begin
            ptr_reg <= (ptr_reg == '0) ? HEAD_LAST : ptr_reg - 1'b1;
        end
    end

    // Position differences of adjacent entries, newest first.
    assign dx    = {rd_data_reg.x[15], rd_data_reg.x} - {prev_x_reg[15], prev_x_reg};
    assign dy    = {rd_data_reg.y[15], rd_data_reg.y} - {prev_y_reg[15], prev_y_reg};
    assign dist2 = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    // Walk pipeline: read, absolute difference, square, compare.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            f1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            jump_reg  <= 1'b0;
            cnt_r_reg <= '0;
            cnt_y_reg <= '0;
            cnt_g_reg <= '0;
        end
        else
        begin
            v1_reg <= cmd.walk_rd;
            f1_reg <= cmd.walk_first;
            v2_reg <= v1_reg && !f1_reg;
            v3_reg <= v2_reg;
            if (cmd.take)
            begin
                jump_reg  <= 1'b0;
                cnt_r_reg <= '0;
                cnt_y_reg <= '0;
                cnt_g_reg <= '0;
            end
            else
            begin
                if (v1_reg)
                begin
                    cnt_r_reg <= cnt_r_reg + CNT_W'(rd_data_reg.lamps[0]);
                    cnt_y_reg <= cnt_y_reg + CNT_W'(rd_data_reg.lamps[1]);
                    cnt_g_reg <= cnt_g_reg + CNT_W'(rd_data_reg.lamps[2]);
                end
                if (v3_reg && !(dist2 < {1'b0, lim_reg}))
                    jump_reg <= 1'b1;
            end
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prev_x_reg <= rd_data_reg.x;
            prev_y_reg <= rd_data_reg.y;
            adx_reg    <= dx[16] ? 16'(-dx) : dx[15:0];
            ady_reg    <= dy[16] ? 16'(-dy) : dy[15:0];
        end
        if (v2_reg)
        begin
            sqx_reg <= 32'(adx_reg) * 32'(adx_reg);
            sqy_reg <= 32'(ady_reg) * 32'(ady_reg);
        end
    end

    // Result selection from the kind of word and the walk outcome.
    always_comb
    begin
        vote_r     = vote_lamp(cnt_r_reg, tol_reg);
        vote_y     = vote_lamp(cnt_y_reg, tol_reg);
        vote_g     = vote_lamp(cnt_g_reg, tol_reg);
        report     = 1'b0;
        res_states = held_reg;
        res_ready  = 1'b0;
        res_status = STAT_MISS;
        case (kind_reg)
            KIND_PARTIAL:
            begin
                report     = 1'b1;
                res_states = {1'b0, item_lamps_reg[2], 1'b0, item_lamps_reg[1],
                              1'b0, item_lamps_reg[0]};
                res_status = STAT_PARTIAL;
            end
            KIND_WALK:
            begin
                if (jump_reg)
                    res_status = STAT_JUMP;
                else if (vote_r == LAMP_UNDEC || vote_y == LAMP_UNDEC ||
                         vote_g == LAMP_UNDEC)
                    res_status = STAT_UNDECIDED;
                else
                begin
                    report     = 1'b1;
                    res_states = {vote_g, vote_y, vote_r};
                    res_ready  = 1'b1;
                    res_status = STAT_VOTED;
                end
            end
            default:
            begin
                res_status = STAT_MISS;
            end
        endcase
    end

    // Saturating visibility count: reports count up, failures count down.
    always_comb
    begin
        if (report)
        begin
            if (vis_reg < 0)
                vis_next = 16'sd1;
            else if (vis_reg == VIS_MAX)
                vis_next = vis_reg;
            else
                vis_next = vis_reg + 16'sd1;
        end
        else
        begin
            if (vis_reg >= 0)
                vis_next = -16'sd1;
            else if (vis_reg == VIS_MIN)
                vis_next = vis_reg;
            else
                vis_next = vis_reg - 16'sd1;
        end
    end

    // Held states, visibility and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vis_reg       <= VIS_RESET;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                vis_reg       <= vis_next;
                held_reg      <= res_states;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_states_reg <= res_states;
            out_ready_reg  <= res_ready;
            out_vis_reg    <= vis_next;
            out_status_reg <= res_status;
        end
    end

    assign dp_st.kind     = kind_reg;
    assign dp_st.out_free = !out_valid_reg || m_tready;
    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = {2'b00, out_vis_reg, out_states_reg};
    assign m_tuser        = {out_status_reg, out_ready_reg};

endmodule

### src/signal_light_history_voter.sv
// Top level of the signal light history voter.
// Depends on slhv_pkg, slhv_ctrl and slhv_datapath.
//
//  Channel   Signals                             Moves
//  s_*       s_tvalid s_tready s_tdata s_tuser   one frame or miss word in
//  m_*       m_tvalid m_tready m_tdata m_tuser   one result word out
//  cfg_*     cfg_valid cfg_ready cfg_index       one register write
//            cfg_data
//
// A frame word on a full ring goes from accept through the decide state and the walk
// (one ring read per cycle), then the drain state for the difference, square and compare
// stages, then the finish state. A miss word or a frame on a partly filled ring goes from decide to finish.
// A result waits in the output register while m_tready is low; the next word is
// taken meanwhile and held at its end until the register is free.
// Reset is asynchronous and active low; the ring needs no clearing pass.
module signal_light_history_voter
    import slhv_pkg::*;
#(
    parameter int HISTORY_DEPTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input word.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [39:0]            s_tdata,   // red_on, yellow_on, green_on, pos_x_mm, pos_y_mm
    input  logic [1:0]             s_tuser,   // cmd
    // Result word.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,   // red_state, yellow_state, green_state, visibility
    output logic [3:0]             m_tuser,   // ready_res, status
    // Register writes.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_st;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    slhv_ctrl #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .dp_st    (dp_st),
        .cmd      (cmd)
    );

    slhv_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .dp_st     (dp_st),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
